[src/esbg_pkg.sv]
// Shared constants, types and the quarter-wave sine table for the beep generator.
// No dependencies; every other file imports this package.
`default_nettype none

package esbg_pkg;

  // Audio format. The sample rate is a whole number of kHz.
  localparam int SAMPLE_RATE     = 16000;
  localparam int FADE_SAMPLES    = 160;
  localparam int SINE_TABLE_BITS = 10;
  localparam int AMPLITUDE       = 16000;
  localparam int QTR             = 1 << SINE_TABLE_BITS;
  localparam int SPM             = SAMPLE_RATE / 1000;  // samples per ms

  // Field widths
  localparam int FREQ_W     = 13;
  localparam int LEN_W      = 12;
  localparam int SAMPLE_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Derived internal widths
  localparam int AMP_W     = $clog2(AMPLITUDE + 1);
  localparam int PH_W      = $clog2(SAMPLE_RATE);
  localparam int M_W       = $clog2(SAMPLE_RATE + 1);
  localparam int FRAC_W    = PH_W;
  localparam int TOTAL_W   = $clog2(SPM * ((1 << LEN_W) - 1) + 1);
  localparam int ENV_W     = $clog2(FADE_SAMPLES + 1);
  localparam int ADDR_W    = SINE_TABLE_BITS + 1;
  localparam int J_NUM_W   = M_W + SINE_TABLE_BITS;
  localparam int P_W       = AMP_W + FRAC_W;
  localparam int PM_W      = AMP_W + ENV_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_FREQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_LEN  = CFG_IDX_W'(1);

  localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(880);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(120);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [AMP_W-1:0] sine_tab_t [0:QTR];

  // Load enables of the two register stages of a constant divider
  typedef struct packed {
    logic mul;
    logic fix;
  } cdiv_en_t;

  // round(A * sin(pi/2 * k / QTR)) from a Q30 Taylor series, evaluated at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t         tab;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   ent;
    longint            sum;
    for (int k = 0; k <= QTR; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(QTR);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      ent    = ((64'(sum) * 64'(AMPLITUDE)) + (64'd1 << 29)) >> 30;
      tab[k] = AMP_W'(ent);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

[src/esbg_cdiv.sv]
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
// Depends on esbg_pkg (cdiv_en_t).
`default_nettype none

module esbg_cdiv
  import esbg_pkg::*;
#(
  parameter int DIVISOR = 16000,
  parameter int NUM_W   = 24,
  parameter int QUO_W   = 11,
  parameter int REM_W   = 14
) (
  input  wire logic             clk,
  input  wire cdiv_en_t         en,
  input  wire logic [NUM_W-1:0] num,
  output logic      [QUO_W-1:0] quo,
  output logic      [REM_W-1:0] rem
);

  // floor(2^NUM_W / D): estimate is exact or one low, since num < 2^NUM_W
  localparam longint unsigned RECIP = (longint'(1) << NUM_W) / longint'(DIVISOR);
  localparam int R_W = $clog2(RECIP + 1);
  localparam int PR_W = NUM_W + R_W;
  localparam logic [R_W-1:0]   RECIP_C = R_W'(RECIP);
  localparam logic [NUM_W-1:0] DIV_C   = NUM_W'(DIVISOR);

  logic [NUM_W-1:0] num_q;
  logic [PR_W-1:0]  prod;
  logic [R_W-1:0]   est;
  logic [NUM_W-1:0] rem_raw;
  logic             fix;

  always_ff @(posedge clk) begin
    if (en.mul) begin
      num_q <= num;
      prod  <= PR_W'(num) * PR_W'(RECIP_C);
    end
  end

  always_comb begin
    est     = prod[PR_W-1:NUM_W];
    rem_raw = num_q - (NUM_W'(est) * DIV_C);
    fix     = (rem_raw >= DIV_C);
  end

  always_ff @(posedge clk) begin
    if (en.fix) begin
      quo <= QUO_W'(est + R_W'(fix));
      rem <= fix ? REM_W'(rem_raw - DIV_C) : REM_W'(rem_raw);
    end
  end

endmodule

`default_nettype wire

[src/esbg_sine_rom.sv]
// Quarter-wave sine ROM, two read ports, registered read data.
// Depends on esbg_pkg (table builder and widths).
`default_nettype none

module esbg_sine_rom
  import esbg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [ADDR_W-1:0] addr_a,
  input  wire logic [ADDR_W-1:0] addr_b,
  output logic      [AMP_W-1:0]  data_a,
  output logic      [AMP_W-1:0]  data_b
);

  localparam sine_tab_t SINE_ROM = build_sine_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= SINE_ROM[addr_a];
      data_b <= SINE_ROM[addr_b];
    end
  end

endmodule

`default_nettype wire

[src/enveloped_sine_beep_generator_unit.sv]
// Top level of the enveloped sine beep generator: control state, 13-stage sample pipeline.
// Depends on esbg_pkg, esbg_cdiv and esbg_sine_rom.
//
//   channel  signals                                   direction  width
//   -------  ----------------------------------------  ---------  -----------------
//   in       in_valid / in_ready / start_req           sink       1
//   out      out_valid / out_ready / sample/active/last source    15 signed, 1, 1
//   cfg      cfg_valid / cfg_ready / cfg_index/cfg_data sink      2 index, 13 data
//
// One word in, one word out. A word is accepted every cycle unless the full pipeline
// is held by a stalled output; its result passes through three constant dividers of
// two stages each, the ROM read, the multiply stages and the register stages around them.
// Beep state (index, phase, running) advances at accept time, so a word may
// follow in the very next cycle. Each stage stalls only when the one after it
// is full and stalled, so bubbles are squeezed out while the output waits.
// Synchronous reset clears beep state and valid bits and sets the config registers to
// their reset values; the sine ROM is constant, needs no clearing. cfg is always ready.
`default_nettype none

module enveloped_sine_beep_generator_unit
  import esbg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   start_req,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [SAMPLE_W-1:0]  sample,
  output logic                        active,
  output logic                        last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NSTG = 13;

  // per-word flags that ride along the pipeline
  typedef struct packed {
    logic neg;   // lower half of the wave
    logic act;   // word belongs to a beep
    logic fin;   // final word of the beep
  } tag_t;

  localparam logic [PH_W:0]     SR_X   = (PH_W + 1)'(SAMPLE_RATE);
  localparam logic [PH_W+1:0]   SR_1   = (PH_W + 2)'(SAMPLE_RATE);
  localparam logic [PH_W+1:0]   SR_2   = (PH_W + 2)'(2 * SAMPLE_RATE);
  localparam logic [PH_W+1:0]   SR_3   = (PH_W + 2)'(3 * SAMPLE_RATE);
  localparam logic [M_W-1:0]    SR_M   = M_W'(SAMPLE_RATE);
  localparam logic [TOTAL_W:0]  FADE_X = (TOTAL_W + 1)'(FADE_SAMPLES);
  localparam logic [TOTAL_W-1:0] FADE_T = TOTAL_W'(FADE_SAMPLES);
  localparam logic [ENV_W-1:0]  FADE_E = ENV_W'(FADE_SAMPLES);
  localparam logic [ADDR_W-1:0] QTR_A  = ADDR_W'(QTR);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FREQ_W-1:0] tone_frequency_hz;
  logic [LEN_W-1:0]  tone_length_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_frequency_hz <= FREQ_RESET;
      tone_length_ms    <= LEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_TONE_FREQ) begin
        tone_frequency_hz <= cfg_data[FREQ_W-1:0];
      end else if (cfg_index == CFG_TONE_LEN) begin
        tone_length_ms <= cfg_data[LEN_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids and load enables. ld[k] loads stage k from stage k-1.
  // ---------------------------------------------------------------------------
  logic [NSTG:1]   v;
  logic [NSTG+1:1] ld;
  logic            in_fire;

  always_comb begin
    ld[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[1];
  assign in_fire   = in_valid && ld[1];
  assign out_valid = v[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (ld[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Beep state, updated at accept
  // ---------------------------------------------------------------------------
  logic [TOTAL_W-1:0] sample_index;
  logic [PH_W-1:0]    phase;
  logic               running;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] idx0;
  logic [PH_W-1:0]    ph0;
  logic               run0;
  logic               act0;
  logic               fin0;
  logic [ENV_W-1:0]   env0;
  logic [PH_W:0]      freq_x;
  logic [PH_W:0]      step;
  logic [PH_W:0]      ph_sum;
  logic [PH_W-1:0]    ph_next;

  always_comb begin
    total = TOTAL_W'(tone_length_ms) * TOTAL_W'(SPM);
    // a start request restarts the beep on this very word
    idx0  = start_req ? '0 : sample_index;
    ph0   = start_req ? '0 : phase;
    run0  = start_req || running;
    act0  = run0 && (idx0 < total);
    fin0  = act0 && ((idx0 + TOTAL_W'(1)) == total);

    // fade-in wins over fade-out
    if (idx0 < FADE_T) begin
      env0 = ENV_W'(idx0);
    end else if (({1'b0, idx0} + FADE_X) > {1'b0, total}) begin
      env0 = ENV_W'(total - idx0);
    end else begin
      env0 = FADE_E;
    end

    freq_x  = (PH_W + 1)'(tone_frequency_hz);
    step    = (freq_x >= SR_X) ? (freq_x - SR_X) : freq_x;
    ph_sum  = {1'b0, ph0} + step;
    ph_next = (ph_sum >= SR_X) ? PH_W'(ph_sum - SR_X) : PH_W'(ph_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      phase        <= '0;
      running      <= 1'b0;
    end else if (in_fire) begin
      if (act0) begin
        sample_index <= idx0 + TOTAL_W'(1);
        phase        <= ph_next;
        running      <= !fin0;
      end else begin
        sample_index <= idx0;
        phase        <= ph0;
        running      <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accepted word
  // ---------------------------------------------------------------------------
  logic [PH_W-1:0]  s1_ph;
  logic [ENV_W-1:0] s1_env;
  logic             s1_act;
  logic             s1_fin;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_ph  <= ph0;
      s1_env <= env0;
      s1_act <= act0;
      s1_fin <= fin0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: quadrant and mirrored position m (table steps = m * QTR / SR)
  // ---------------------------------------------------------------------------
  logic [PH_W+1:0] ph4;
  logic [PH_W+1:0] quad_base;
  logic [1:0]      quad;
  logic [M_W-1:0]  rpos;
  logic [M_W-1:0]  m_pos;

  always_comb begin
    ph4 = {s1_ph, 2'b00};
    priority if (ph4 >= SR_3) begin
      quad      = 2'd3;
      quad_base = SR_3;
    end else if (ph4 >= SR_2) begin
      quad      = 2'd2;
      quad_base = SR_2;
    end else if (ph4 >= SR_1) begin
      quad      = 2'd1;
      quad_base = SR_1;
    end else begin
      quad      = 2'd0;
      quad_base = '0;
    end
    rpos  = M_W'(ph4 - quad_base);
    m_pos = quad[0] ? (SR_M - rpos) : rpos;
  end

  logic [M_W-1:0]   s2_m;
  logic [ENV_W-1:0] s2_env;
  tag_t             s2_tag;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_m   <= m_pos;
      s2_env <= s1_env;
      s2_tag <= '{neg: quad[1], act: s1_act, fin: s1_fin};
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 3-4: table index j and fraction
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] tab_j;
  logic [FRAC_W-1:0] tab_frac;

  esbg_cdiv #(
    .DIVISOR (SAMPLE_RATE),
    .NUM_W   (J_NUM_W),
    .QUO_W   (ADDR_W),
    .REM_W   (FRAC_W)
  ) u_div_pos (
    .clk (clk),
    .en  ('{mul: ld[3], fix: ld[4]}),
    .num ({s2_m, {SINE_TABLE_BITS{1'b0}}}),
    .quo (tab_j),
    .rem (tab_frac)
  );

  logic [ENV_W-1:0] s3_env, s4_env;
  tag_t             s3_tag, s4_tag;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_env <= s2_env;
      s3_tag <= s2_tag;
    end
    if (ld[4]) begin
      s4_env <= s3_env;
      s4_tag <= s3_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: ROM read of both neighbors; the quarter peak reads itself twice
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0]  rom_a;
  logic [AMP_W-1:0]  rom_b;
  logic [ADDR_W-1:0] addr_b;

  assign addr_b = (tab_j == QTR_A) ? tab_j : (tab_j + ADDR_W'(1));

  esbg_sine_rom u_rom (
    .clk    (clk),
    .en     (ld[5]),
    .addr_a (tab_j),
    .addr_b (addr_b),
    .data_a (rom_a),
    .data_b (rom_b)
  );

  logic [FRAC_W-1:0] s5_frac;
  logic [ENV_W-1:0]  s5_env;
  tag_t              s5_tag;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_frac <= tab_frac;
      s5_env  <= s4_env;
      s5_tag  <= s4_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: slope times fraction
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0] slope;

  assign slope = (rom_b < rom_a) ? '0 : (rom_b - rom_a);

  logic [P_W-1:0]   s6_p;
  logic [AMP_W-1:0] s6_a;
  logic [ENV_W-1:0] s6_env;
  tag_t             s6_tag;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_p   <= P_W'(slope) * P_W'(s5_frac);
      s6_a   <= rom_a;
      s6_env <= s5_env;
      s6_tag <= s5_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 7-8: interpolation step = slope * frac / SR
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0] interp;

  esbg_cdiv #(
    .DIVISOR (SAMPLE_RATE),
    .NUM_W   (P_W),
    .QUO_W   (AMP_W),
    .REM_W   (FRAC_W)
  ) u_div_interp (
    .clk (clk),
    .en  ('{mul: ld[7], fix: ld[8]}),
    .num (s6_p),
    .quo (interp),
    .rem ()
  );

  logic [AMP_W-1:0] s7_a, s8_a;
  logic [ENV_W-1:0] s7_env, s8_env;
  tag_t             s7_tag, s8_tag;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s7_a   <= s6_a;
      s7_env <= s6_env;
      s7_tag <= s6_tag;
    end
    if (ld[8]) begin
      s8_a   <= s7_a;
      s8_env <= s7_env;
      s8_tag <= s7_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: magnitude; stage 10: times envelope
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0] s9_mag;
  logic [ENV_W-1:0] s9_env;
  tag_t             s9_tag;
  logic [PM_W-1:0]  s10_pm;
  tag_t             s10_tag;

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      s9_mag <= s8_a + interp;
      s9_env <= s8_env;
      s9_tag <= s8_tag;
    end
    if (ld[10]) begin
      s10_pm  <= PM_W'(s9_mag) * PM_W'(s9_env);
      s10_tag <= s9_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 11-12: divide by the fade length
  // ---------------------------------------------------------------------------
  logic [AMP_W-1:0] faded;

  esbg_cdiv #(
    .DIVISOR (FADE_SAMPLES),
    .NUM_W   (PM_W),
    .QUO_W   (AMP_W),
    .REM_W   (ENV_W)
  ) u_div_fade (
    .clk (clk),
    .en  ('{mul: ld[11], fix: ld[12]}),
    .num (s10_pm),
    .quo (faded),
    .rem ()
  );

  tag_t s11_tag, s12_tag;

  always_ff @(posedge clk) begin
    if (ld[11]) begin
      s11_tag <= s10_tag;
    end
    if (ld[12]) begin
      s12_tag <= s11_tag;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 13: output register, sign applied, idle words forced to zero
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] mag_s;

  assign mag_s = SAMPLE_W'(faded);

  always_ff @(posedge clk) begin
    if (ld[13]) begin
      if (!s12_tag.act) begin
        sample <= '0;
      end else if (s12_tag.neg) begin
        sample <= $signed(SAMPLE_W'(0) - mag_s);
      end else begin
        sample <= $signed(mag_s);
      end
      active <= s12_tag.act;
      last   <= s12_tag.fin;
    end
  end

endmodule

`default_nettype wire

[src/esbg_checker.sv]
// Port-level checks for the beep generator, bound to the top level.
// Depends on esbg_pkg (widths, amplitude).
`default_nettype none

module esbg_checker
  import esbg_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic signed [SAMPLE_W-1:0] sample,
  input wire logic                  active,
  input wire logic                  last
);

  localparam logic signed [SAMPLE_W-1:0] AMP_S = SAMPLE_W'(AMPLITUDE);

  // an empty output register means nothing can hold the input back
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !active) |-> (sample == '0))
    else $error("nonzero sample outside a beep");

  a_last_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> active)
    else $error("last without active");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((sample <= AMP_S) && (sample >= -AMP_S)))
    else $error("sample beyond amplitude");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample) && $stable(last)))
    else $error("stalled word changed");

endmodule

bind enveloped_sine_beep_generator_unit esbg_checker u_esbg_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the enveloped sine beep generator: a directed table, then random beeps.
// Depends on esbg_pkg and enveloped_sine_beep_generator_unit. A local predictor computes
// the expected sample words; typed directed rows give their own.

module tb;
  import esbg_pkg::*;

  // Audio format. The predictor keeps its own copy, not the RTL package's audio values.
  localparam int unsigned RATE_HZ     = 16000;
  localparam int unsigned FADE_LEN    = 160;
  localparam int unsigned QW_STEPS    = 1024;          // quarter-wave table steps
  localparam int unsigned PEAK_AMP    = 16000;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam logic [12:0] FREQ_AT_RESET = 13'd880;
  localparam logic [11:0] LEN_AT_RESET  = 12'd120;

  // These indexes are not decoded by the block, so a write to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

  // Run shape
  localparam int SETTLE       = 16;      // pipeline is 13 deep, so this leaves some margin
  localparam int WORD_TARGET  = 1550;
  localparam int PHASE_WORDS  = 120;
  localparam int MIN_PHASES   = 8;
  localparam int RUN_CAP      = 420;
  localparam int HOLD_CYCLES  = 64;
  localparam int LIMIT        = 200000;
  localparam int SEND_GAP_PCT = 78;
  localparam int SINK_STALL_PCT = 78;
  localparam int BOTH_PCT     = 9;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

  // One output word as the block presents it.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic                       last;
  } beep_word_t;

  localparam beep_word_t IDLE_WORD     = '0;
  // First sample of any beep: the fade-in gain is zero there. This word also results
  // whenever the phase stays at zero, except on the last word of a beep.
  localparam beep_word_t SILENT_ACTIVE = '{sample: '0, active: 1'b1, last: 1'b0};

  // A directed row is either a register write or a run of identical input words. When
  // typed is set, the expected word is the one given in the row and not the predicted one.
  typedef struct packed {
    logic                  reg_write;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  start;
    logic [4:0]            reps;
    logic                  typed;
    beep_word_t            want;
  } plan_row_t;

  localparam int PLAN_ROWS = 20;

  //                 reg  index          value     start reps  typed  expected
  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{1'b0, '0,            13'd0,    1'b0, 5'd1,  1'b1, IDLE_WORD},     // idle out of reset
    '{1'b0, '0,            13'd0,    1'b1, 5'd1,  1'b1, SILENT_ACTIVE}, // start, reset settings
    '{1'b0, '0,            13'd0,    1'b0, 5'd1,  1'b0, IDLE_WORD},
    '{1'b0, '0,            13'd0,    1'b1, 5'd1,  1'b1, SILENT_ACTIVE}, // restart mid-beep
    '{1'b1, CFG_TONE_LEN,  13'd0,    1'b0, 5'd0,  1'b0, IDLE_WORD},
    '{1'b0, '0,            13'd0,    1'b0, 5'd1,  1'b1, IDLE_WORD},     // shrunk length ends beep
    '{1'b0, '0,            13'd0,    1'b1, 5'd1,  1'b1, IDLE_WORD},     // start, zero length
    '{1'b1, CFG_TONE_LEN,  13'd1,    1'b0, 5'd0,  1'b0, IDLE_WORD},     // 16 samples, all fade-in
    '{1'b1, CFG_TONE_FREQ, 13'd4000, 1'b0, 5'd0,  1'b0, IDLE_WORD},
    '{1'b0, '0,            13'd0,    1'b1, 5'd1,  1'b1, SILENT_ACTIVE},
    '{1'b0, '0,            13'd0,    1'b0, 5'd15, 1'b0, IDLE_WORD},     // up to the last sample
    '{1'b0, '0,            13'd0,    1'b0, 5'd1,  1'b1, IDLE_WORD},     // beep is over
    '{1'b1, CFG_TONE_FREQ, 13'h1FFF, 1'b0, 5'd0,  1'b0, IDLE_WORD},     // aliased frequency
    '{1'b1, CFG_TONE_LEN,  13'h1FFF, 1'b0, 5'd0,  1'b0, IDLE_WORD},     // top bit dropped
    '{1'b1, CFG_SPARE_A,   13'h0AAA, 1'b0, 5'd0,  1'b0, IDLE_WORD},
    '{1'b1, CFG_SPARE_B,   13'h1555, 1'b0, 5'd0,  1'b0, IDLE_WORD},
    '{1'b0, '0,            13'd0,    1'b1, 5'd1,  1'b1, SILENT_ACTIVE}, // longest beep
    '{1'b1, CFG_TONE_FREQ, 13'd0,    1'b0, 5'd0,  1'b0, IDLE_WORD},
    '{1'b0, '0,            13'd0,    1'b1, 5'd1,  1'b1, SILENT_ACTIVE}, // zero frequency
    '{1'b0, '0,            13'd0,    1'b0, 5'd1,  1'b1, SILENT_ACTIVE}  // stays silent
  };

  // DUT ports
  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          start_req;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_W-1:0]    sample;
  logic                          active;
  logic                          last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;

  // Predictor state. It mirrors the beep state at input-accept time.
  int unsigned  quarter_wave [0:QW_STEPS];
  logic [12:0]  tone_freq;
  logic [11:0]  tone_len;
  int unsigned  beep_index;
  int unsigned  beep_phase;
  logic         beep_running;

  beep_word_t   beep_words_due [$];      // expected words, oldest first

  // Bookkeeping
  idle_mode_t   idle_mode;
  logic         hold_go;
  int           words_in;
  int           words_out;
  int           beeps_done;
  int           regs_written;
  int           mismatches;
  int           input_stalls;
  int           cycles;

  enveloped_sine_beep_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .active    (active),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Quarter-wave sine table: round(PEAK * sin(pi/2 * k / QW_STEPS)). The sine is a Q30
  // Taylor series up to x^13, as the block builds it.
  function automatic void fill_quarter_wave();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k <= QW_STEPS; k++) begin
      x    = (64'(k) * PI_HALF_Q30) / 64'(QW_STEPS);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      quarter_wave[k] = int'((64'(acc) * 64'(PEAK_AMP) + (64'd1 << 29)) >> 30);
    end
  endfunction

  // Sine magnitude at a phase given in Hz-samples, modulo RATE_HZ. Quadrants 1 and 3
  // mirror the table. Quadrants 2 and 3 set neg.
  function automatic int unsigned wave_mag(input int unsigned ph, output logic neg);
    longint unsigned span;
    longint unsigned pos;
    longint unsigned quad;
    longint unsigned j;
    longint unsigned frac;
    int unsigned     a;
    int unsigned     b;
    span = 64'(QW_STEPS) * 64'(RATE_HZ);
    pos  = 64'(ph) * 64'd4 * 64'(QW_STEPS);
    quad = (pos / span) & 64'd3;
    pos  = pos % span;
    if (quad[0]) begin
      pos = span - pos;
    end
    neg  = (quad >= 64'd2);
    j    = pos / 64'(RATE_HZ);
    frac = pos % 64'(RATE_HZ);
    if (j >= 64'(QW_STEPS)) begin
      return quarter_wave[QW_STEPS];
    end
    a = quarter_wave[int'(j)];
    b = quarter_wave[int'(j) + 1];
    if (b < a) begin
      b = a;
    end
    return a + int'((64'(b - a) * frac) / 64'(RATE_HZ));
  endfunction

  // Advances the beep state by one tick and returns the word this tick produces.
  function automatic beep_word_t next_beep_word(input logic st);
    beep_word_t  w;
    int unsigned total;
    int unsigned mag;
    int unsigned env;
    int unsigned v;
    int unsigned i;
    logic        neg;
    total = (RATE_HZ * int'(tone_len)) / 1000;
    if (st) begin
      beep_running = 1'b1;
      beep_index   = 0;
      beep_phase   = 0;
    end
    w = IDLE_WORD;
    if (beep_running && beep_index < total) begin
      mag = wave_mag(beep_phase, neg);
      i   = beep_index;
      // linear fade at both ends; the fade-in test goes first
      if (i < FADE_LEN) begin
        env = i;
      end else if (i + FADE_LEN > total) begin
        env = total - i;
      end else begin
        env = FADE_LEN;
      end
      v        = (mag * env) / FADE_LEN;
      w.sample = SAMPLE_W'(neg ? (32'd0 - v) : v);
      w.active = 1'b1;
      w.last   = (i + 1 == total);
      beep_index = i + 1;
      beep_phase = beep_phase + (int'(tone_freq) % RATE_HZ);
      if (beep_phase >= RATE_HZ) begin
        beep_phase = beep_phase - RATE_HZ;
      end
      if (w.last) begin
        beep_running = 1'b0;
      end
    end else begin
      beep_running = 1'b0;
    end
    return w;
  endfunction

  // Offers one input word, with optional idle cycles before it. Starts and ends just
  // after a falling edge. in_valid is left high, so a word that follows at once keeps
  // valid up without a glitch. Any caller that lets time pass lowers it first.
  task automatic send_word(input logic st, input logic typed, input beep_word_t want);
    int         gaps;
    int         pct;
    beep_word_t predicted;
    pct  = (idle_mode == IDLE_SOURCE) ? SEND_GAP_PCT :
           (idle_mode == IDLE_BOTH)   ? BOTH_PCT : 0;
    gaps = 0;
    while ($urandom_range(0, 99) < pct) begin
      gaps++;
    end
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= st;
    do @(posedge clk); while (!in_ready);
    // the beep state moves when the word is accepted, so predict here
    predicted = next_beep_word(st);
    beep_words_due.push_back(typed ? want : predicted);
    words_in++;
    @(negedge clk);
  endtask

  // Register write. Only called while the pipeline is empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TONE_FREQ: tone_freq = val;
      CFG_TONE_LEN:  tone_len  = val[11:0];
      default: ;                                 // spare index: dropped
    endcase
    regs_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering words, wait for every outstanding word, then let the pipe go quiet.
  task automatic wait_for_results(input int settle);
    in_valid <= 1'b0;
    while (beep_words_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(negedge clk);
  endtask

  // Receiver side: decides out_ready at each falling edge. One long hold-off is taken
  // the first time hold_go is seen. The sender keeps offering words during it, so the
  // pipeline backs up and in_ready drops.
  initial begin
    int   hold_left;
    logic hold_taken;
    int   pct;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      pct = (idle_mode == IDLE_SINK) ? SINK_STALL_PCT :
            (idle_mode == IDLE_BOTH) ? BOTH_PCT : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  // Output checker: each accepted word is compared with the oldest expected word.
  always @(posedge clk) begin
    beep_word_t got;
    beep_word_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{sample: sample, active: active, last: last};
      words_out++;
      if (got.last === 1'b1) begin
        beeps_done++;
      end
      if (beep_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected word: sample %0d active %0b last %0b",
                   got.sample, got.active, got.last);
        end
      end else begin
        want = beep_words_due.pop_front();
        if (got.sample !== want.sample || got.active !== want.active ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("word %0d: expected sample %0d active %0b last %0b, got %0d %0b %0b",
                     words_out, want.sample, want.active, want.last,
                     got.sample, got.active, got.last);
          end
        end
      end
    end
  end

  // Watchdog and back-pressure count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_valid && !in_ready) begin
      input_stalls <= input_stalls + 1;
    end
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, beep_words_due.size());
      $display("tb failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int          ph;
    int          phase_end;
    int          roll;
    int          run;
    int          total;
    logic        paused;
    logic [12:0] f_pick;
    logic [11:0] l_pick;
    logic [CFG_DATA_W-1:0] l_data;

    rst          = 1'b1;
    in_valid     = 1'b0;
    start_req    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_mode    = IDLE_NONE;
    hold_go      = 1'b0;
    words_in     = 0;
    words_out    = 0;
    beeps_done   = 0;
    regs_written = 0;
    mismatches   = 0;
    input_stalls = 0;
    cycles       = 0;
    tone_freq    = FREQ_AT_RESET;
    tone_len     = LEN_AT_RESET;
    beep_index   = 0;
    beep_phase   = 0;
    beep_running = 1'b0;
    fill_quarter_wave();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: no idling. A register row waits for the pipe to drain first.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].reg_write) begin
        wait_for_results(SETTLE);
        write_reg(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        repeat (int'(plan[r].reps)) send_word(plan[r].start, plan[r].typed, plan[r].want);
      end
    end

    // Random part: each phase takes new settings and one idling mode. Most of the
    // stimulus is whole beeps: a start, then enough ticks to reach the last sample and
    // a few idle ticks after it. The rest is cut-short beeps and random start noise.
    ph     = 0;
    paused = 1'b0;
    while (words_in < WORD_TARGET || ph < MIN_PHASES) begin
      idle_mode = idle_mode_t'(ph % 4);
      wait_for_results(SETTLE);

      roll = $urandom_range(0, 7);
      case (roll)
        0:       f_pick = 13'd0;
        1:       f_pick = 13'h1FFF;
        2:       f_pick = 13'd7999;
        3:       f_pick = 13'd8000;
        default: f_pick = 13'($urandom_range(1, 8190));
      endcase
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        l_pick = 12'd0;
      end else if (roll == 1) begin
        l_pick = $urandom_range(0, 1) ? 12'd4095 : 12'($urandom_range(26, 4095));
      end else if (roll <= 6) begin
        l_pick = 12'($urandom_range(1, 8));
      end else begin
        l_pick = 12'($urandom_range(9, 25));                // 9-25 ms; full plateau only from 20 ms up
      end
      l_data = {1'($urandom_range(0, 1)), l_pick};         // the top bit must be ignored

      if ($urandom_range(0, 1)) begin
        write_reg(CFG_TONE_FREQ, f_pick);
        write_reg(CFG_TONE_LEN, l_data);
      end else begin
        write_reg(CFG_TONE_LEN, l_data);
        write_reg(CFG_TONE_FREQ, f_pick);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  CFG_DATA_W'($urandom_range(0, 8191)));
      end

      // back-pressure test in a phase where the sender never idles
      if (ph == 4) begin
        hold_go = 1'b1;
      end

      phase_end = words_in + PHASE_WORDS;
      while (words_in < phase_end) begin
        // Once, midway through phase 5, the sender waits until every result is out.
        if (ph == 5 && !paused && words_in >= phase_end - PHASE_WORDS / 2) begin
          wait_for_results(1);
          paused = 1'b1;
        end
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
          repeat ($urandom_range(1, 8)) send_word(1'($urandom_range(0, 1)), 1'b0, IDLE_WORD);
        end else begin
          repeat ($urandom_range(0, 2)) send_word(1'b0, 1'b0, IDLE_WORD);
          send_word(1'b1, 1'b0, IDLE_WORD);
          total = (RATE_HZ * int'(tone_len)) / 1000;
          run   = (roll <= 2) ? $urandom_range(0, total) : total + $urandom_range(0, 3);
          if (run > RUN_CAP) begin
            run = RUN_CAP;
          end
          repeat (run) send_word(1'b0, 1'b0, IDLE_WORD);
        end
      end
      ph++;
    end

    wait_for_results(SETTLE);

    $display("%0d words in %0d phases, %0d register writes, %0d beeps played to the end",
             words_in, ph, regs_written, beeps_done);
    $display("%0d cycles with input back-pressure, %0d mismatching words",
             input_stalls, mismatches);
    if (mismatches == 0 && beep_words_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/esbg_pkg.sv
src/esbg_cdiv.sv
src/esbg_sine_rom.sv
src/enveloped_sine_beep_generator_unit.sv
src/esbg_checker.sv
tb/sv/tb.sv
